// ===== rtl/mpq_pkg.sv =====
// Shared types and constants for the max-priority queue core.
`timescale 1ns / 1ps
package mpq_pkg;

  localparam int QUEUE_DEPTH   = 64;
  localparam int ADDR_W        = $clog2(QUEUE_DEPTH);
  localparam int CNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W        = 32;
  localparam int ENTRY_COUNT_W = 7;
  localparam int S_TDATA_W     = 104;  // 2 + 3 * 32 bits, padded to bytes
  localparam int M_TDATA_W     = 80;   // 32 + 32 + 2 + 7 bits, padded to bytes

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_FIND    = 2'd2,
    CMD_MODIFY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_EMPTY   = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [DATA_W-1:0] prio;
    logic [DATA_W-1:0] value;
  } entry_t;

endpackage

// ===== rtl/mpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module mpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/max_priority_queue_linear_scan_core.sv =====
// Bounded max-priority queue: unsorted entry RAM with a linear scan controller.
// Insert and any request on an empty queue go straight to the result; find and modify
//   scan the stored entries (modify stops at the first match); extract scans, then shifts
//   down the entries after the max when the max at index m is not last.
// Throughput: one item at a time, the next accepted in the cycle after the result is
//   loaded; the scan is set by the single RAM read port, one entry per cycle.
// Reset (rst, synchronous, active high) empties the queue and clears the handshakes;
//   the entry RAM is not cleared, only entries below the count are ever read.
`timescale 1ns / 1ps
module max_priority_queue_linear_scan_core (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // s_tdata: cmd[1:0], value[33:2], priority_req[65:34], old_priority[97:66], zero pad
  input  logic [mpq_pkg::S_TDATA_W-1:0] s_tdata,
  // Result stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // m_tdata: out_value[31:0], out_priority[63:32], status[65:64],
  //          entry_count[72:66], zero pad
  output logic [mpq_pkg::M_TDATA_W-1:0] m_tdata
);

  localparam int AW = mpq_pkg::ADDR_W;
  localparam int CW = mpq_pkg::CNT_W;
  localparam int DW = mpq_pkg::DATA_W;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  mpq_pkg::state_t  state, state_next;
  logic [CW-1:0]    count;        // entries stored
  logic [CW-1:0]    iss;          // next RAM read address to issue
  logic             rd_vld;       // RAM read data valid this cycle
  logic [AW-1:0]    rd_idx;       // address belonging to rd_data

  // latched request
  mpq_pkg::cmd_t    cmd_q;
  logic [DW-1:0]    val_q;
  logic [DW-1:0]    prq_q;
  logic [DW-1:0]    opr_q;

  // running maximum during a scan
  logic [AW-1:0]    best_idx;
  mpq_pkg::entry_t  best;

  // pending result
  mpq_pkg::status_t res_status;
  mpq_pkg::entry_t  res_entry;

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  mpq_pkg::cmd_t in_cmd;
  logic [DW-1:0] in_val, in_prq, in_opr;
  logic          accept;

  assign in_cmd   = mpq_pkg::cmd_t'(s_tdata[1:0]);
  assign in_val   = s_tdata[33:2];
  assign in_prq   = s_tdata[65:34];
  assign in_opr   = s_tdata[97:66];
  assign s_tready = (state == mpq_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // ---------------------------------------------------------------------------
  // Entry RAM
  // ---------------------------------------------------------------------------
  logic            ram_wr_en, ram_rd_en;
  logic [AW-1:0]   ram_wr_addr;
  mpq_pkg::entry_t ram_wr_data, rd_data;

  mpq_ram #(
    .WIDTH ($bits(mpq_pkg::entry_t)),
    .DEPTH (mpq_pkg::QUEUE_DEPTH)
  ) u_entry_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (iss[AW-1:0]),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Scan datapath
  // ---------------------------------------------------------------------------
  logic            is_empty, is_full;
  logic            scanning, issue, last, match, better, out_free, dec_count;
  logic [AW-1:0]   upd_idx;
  mpq_pkg::entry_t upd;

  assign is_empty = (count == '0);
  assign is_full  = (count == CW'(mpq_pkg::QUEUE_DEPTH));
  assign scanning = (state == mpq_pkg::ST_SCAN) || (state == mpq_pkg::ST_SHIFT);
  assign issue    = scanning && (iss < count);
  assign last     = rd_vld && (CW'(rd_idx) == count - CW'(1));
  assign match    = rd_vld && (cmd_q == mpq_pkg::CMD_MODIFY) &&
                    (rd_data.value == val_q) && (rd_data.prio == opr_q);
  // strict greater keeps the earliest arrival on ties; index zero seeds the max
  assign better   = (rd_idx == '0) || ($signed(rd_data.prio) > $signed(best.prio));
  assign upd      = better ? rd_data : best;
  assign upd_idx  = better ? rd_idx : best_idx;
  assign out_free = !m_tvalid || m_tready;

  // extract shrinks the queue when its last move is done
  assign dec_count = (cmd_q == mpq_pkg::CMD_EXTRACT) && last &&
                     (((state == mpq_pkg::ST_SCAN) && (CW'(upd_idx) == count - CW'(1))) ||
                      (state == mpq_pkg::ST_SHIFT));

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      mpq_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == mpq_pkg::CMD_INSERT || is_empty) begin
            state_next = mpq_pkg::ST_RESP;
          end else begin
            state_next = mpq_pkg::ST_SCAN;
          end
        end
      end
      mpq_pkg::ST_SCAN: begin
        if (cmd_q == mpq_pkg::CMD_MODIFY) begin
          if (match || last) begin
            state_next = mpq_pkg::ST_RESP;
          end
        end else if (last) begin
          if (cmd_q == mpq_pkg::CMD_EXTRACT && CW'(upd_idx) != count - CW'(1)) begin
            state_next = mpq_pkg::ST_SHIFT;
          end else begin
            state_next = mpq_pkg::ST_RESP;
          end
        end
      end
      mpq_pkg::ST_SHIFT: begin
        if (last) begin
          state_next = mpq_pkg::ST_RESP;
        end
      end
      mpq_pkg::ST_RESP: begin
        if (out_free) begin
          state_next = mpq_pkg::ST_IDLE;
        end
      end
      default: state_next = mpq_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // RAM control outputs
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_rd_en   = issue;
    ram_wr_en   = 1'b0;
    ram_wr_addr = rd_idx;
    ram_wr_data = rd_data;
    unique case (state)
      mpq_pkg::ST_IDLE: begin
        // append at the tail
        ram_wr_en        = accept && (in_cmd == mpq_pkg::CMD_INSERT) && !is_full;
        ram_wr_addr      = count[AW-1:0];
        ram_wr_data.prio  = in_prq;
        ram_wr_data.value = in_val;
      end
      mpq_pkg::ST_SCAN: begin
        // modify rewrites the first match in place
        ram_wr_en         = match;
        ram_wr_data.prio  = prq_q;
        ram_wr_data.value = val_q;
      end
      mpq_pkg::ST_SHIFT: begin
        // move entry rd_idx down by one place
        ram_wr_en   = rd_vld;
        ram_wr_addr = rd_idx - AW'(1);
      end
      mpq_pkg::ST_RESP: begin
        ram_wr_en = 1'b0;
      end
      default: ram_wr_en = 1'b0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequential logic
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= mpq_pkg::ST_IDLE;
      count    <= '0;
      iss      <= '0;
      rd_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state  <= state_next;
      rd_vld <= issue;

      if (accept) begin
        iss <= '0;
      end else if (state == mpq_pkg::ST_SCAN && last && cmd_q == mpq_pkg::CMD_EXTRACT) begin
        iss <= CW'(upd_idx) + CW'(1);  // shift starts right after the max
      end else if (issue) begin
        iss <= iss + CW'(1);
      end

      if (ram_wr_en && state == mpq_pkg::ST_IDLE) begin
        count <= count + CW'(1);
      end else if (dec_count) begin
        count <= count - CW'(1);
      end

      if (state == mpq_pkg::ST_RESP && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    rd_idx <= iss[AW-1:0];

    if (accept) begin
      cmd_q           <= in_cmd;
      val_q           <= in_val;
      prq_q           <= in_prq;
      opr_q           <= in_opr;
      res_entry       <= '0;
      priority case (1'b1)
        (in_cmd == mpq_pkg::CMD_INSERT): res_status <= is_full ? mpq_pkg::STAT_FULL
                                                               : mpq_pkg::STAT_OK;
        (in_cmd == mpq_pkg::CMD_MODIFY): res_status <= mpq_pkg::STAT_MISSING;
        is_empty:                        res_status <= mpq_pkg::STAT_EMPTY;
        default:                         res_status <= mpq_pkg::STAT_OK;
      endcase
    end

    if (state == mpq_pkg::ST_SCAN && rd_vld) begin
      best     <= upd;
      best_idx <= upd_idx;
      if (match) begin
        res_status <= mpq_pkg::STAT_OK;
      end else if (last && cmd_q != mpq_pkg::CMD_MODIFY) begin
        res_entry <= upd;
      end
    end

    if (state == mpq_pkg::ST_RESP && out_free) begin
      m_tdata <= {7'd0,
                  mpq_pkg::ENTRY_COUNT_W'(count),
                  res_status,
                  res_entry.prio,
                  res_entry.value};
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(mpq_pkg::QUEUE_DEPTH))
    else $error("entry count exceeds queue depth");

  a_no_rw_same_addr: assert property (@(posedge clk) disable iff (rst)
    (ram_wr_en && ram_rd_en) |-> (ram_wr_addr != iss[AW-1:0]))
    else $error("RAM read and write hit the same entry");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == mpq_pkg::CMD_INSERT && !is_full) |=>
      (count == $past(count) + CW'(1)))
    else $error("insert did not grow the queue");

  a_shift_index: assert property (@(posedge clk) disable iff (rst)
    (state == mpq_pkg::ST_SHIFT && rd_vld) |-> (rd_idx != '0))
    else $error("shift moves entry zero");

endmodule

// ===== tb/tb_max_priority_queue_linear_scan_core.sv =====
// Self-checking testbench for the linear-scan max-priority queue core.
`timescale 1ns / 1ps
module tb_max_priority_queue_linear_scan_core;

  // Cycles with no transfer on either side before the run is declared hung.
  // The slowest correct item is an extract on a full queue, and the limit lies well
  // above the long receiver hold-off (HOLD_CYCLES) below.
  localparam int HANG_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_ITEMS = 450;
  localparam int MAX_PRINTED  = 40;

  typedef struct packed {
    mpq_pkg::cmd_t cmd;
    logic [31:0]   value;
    logic [31:0]   prio;
    logic [31:0]   old_prio;
  } request_t;

  typedef struct packed {
    logic [31:0]                       value;
    logic [31:0]                       prio;
    mpq_pkg::status_t                  status;
    logic [mpq_pkg::ENTRY_COUNT_W-1:0] count;
  } result_t;

  typedef struct packed {
    request_t req;
    logic     typed;   // expected result typed into the table
    result_t  res;
  } directed_row_t;

  // Shape of a random run: fill toward full, drain toward empty, or an even mix.
  typedef enum int {
    MIX_FILL,
    MIX_DRAIN,
    MIX_EVEN
  } mix_t;

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [mpq_pkg::S_TDATA_W-1:0] s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [mpq_pkg::M_TDATA_W-1:0] m_tdata;

  // Shadow copy of the queue contents, updated at each accepted request.
  logic [31:0] shadow_value [mpq_pkg::QUEUE_DEPTH];
  logic [31:0] shadow_prio  [mpq_pkg::QUEUE_DEPTH];
  int          shadow_count;

  result_t       awaited_results [$];
  directed_row_t directed_rows [$];

  int mismatches;
  int send_idle_pct;
  int recv_stall_pct;
  bit hold_off_req;
  int quiet_cycles;

  max_priority_queue_linear_scan_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (mismatches < MAX_PRINTED) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
    mismatches++;
  endtask

  // Queue behavior: arrival-ordered store, first max wins, extract shifts down.
  function automatic result_t next_queue_result(input request_t r);
    result_t res;
    int      best;
    res = '0;
    res.status = mpq_pkg::STAT_OK;
    case (r.cmd)
      mpq_pkg::CMD_INSERT: begin
        if (shadow_count >= mpq_pkg::QUEUE_DEPTH) begin
          res.status = mpq_pkg::STAT_FULL;
        end else begin
          shadow_value[shadow_count] = r.value;
          shadow_prio[shadow_count]  = r.prio;
          shadow_count++;
        end
      end
      mpq_pkg::CMD_EXTRACT, mpq_pkg::CMD_FIND: begin
        if (shadow_count == 0) begin
          res.status = mpq_pkg::STAT_EMPTY;
        end else begin
          best = 0;
          // strict compare keeps the earliest arrival on ties
          for (int i = 1; i < shadow_count; i++) begin
            if ($signed(shadow_prio[i]) > $signed(shadow_prio[best])) best = i;
          end
          res.value = shadow_value[best];
          res.prio  = shadow_prio[best];
          if (r.cmd == mpq_pkg::CMD_EXTRACT) begin
            for (int i = best; i < shadow_count - 1; i++) begin
              shadow_value[i] = shadow_value[i + 1];
              shadow_prio[i]  = shadow_prio[i + 1];
            end
            shadow_count--;
          end
        end
      end
      default: begin  // CMD_MODIFY: first entry matching value and old priority
        res.status = mpq_pkg::STAT_MISSING;
        for (int i = 0; i < shadow_count; i++) begin
          if (shadow_value[i] == r.value && shadow_prio[i] == r.old_prio) begin
            shadow_prio[i] = r.prio;
            res.status     = mpq_pkg::STAT_OK;
            break;
          end
        end
      end
    endcase
    res.count = mpq_pkg::ENTRY_COUNT_W'(shadow_count);
    return res;
  endfunction

  // Half full-range words, some in a narrow band so priorities tie and
  // values repeat, some at the extremes.
  function automatic logic [31:0] pick_word();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) return $urandom();
    if (sel < 8) return 32'($urandom_range(0, 8)) - 32'd4;
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  function automatic request_t make_request(input mix_t mix);
    request_t r;
    int       roll;
    int       idx;
    r.value    = pick_word();
    r.prio     = pick_word();
    r.old_prio = $urandom();
    roll       = $urandom_range(0, 99);
    case (mix)
      MIX_FILL:
        r.cmd = roll < 80 ? mpq_pkg::CMD_INSERT : roll < 88 ? mpq_pkg::CMD_FIND :
                roll < 95 ? mpq_pkg::CMD_MODIFY : mpq_pkg::CMD_EXTRACT;
      MIX_DRAIN:
        r.cmd = roll < 75 ? mpq_pkg::CMD_EXTRACT : roll < 85 ? mpq_pkg::CMD_FIND :
                roll < 95 ? mpq_pkg::CMD_MODIFY : mpq_pkg::CMD_INSERT;
      default:
        r.cmd = mpq_pkg::cmd_t'(roll % 4);
    endcase
    // most modifies target a stored entry; some of those miss on priority
    if (r.cmd == mpq_pkg::CMD_MODIFY && shadow_count > 0 && $urandom_range(0, 9) < 7) begin
      idx        = $urandom_range(0, shadow_count - 1);
      r.value    = shadow_value[idx];
      r.old_prio = shadow_prio[idx];
      if ($urandom_range(0, 5) == 0) r.old_prio = r.old_prio + 32'd1;
    end
    return r;
  endfunction

  // Offers one request, waits for the transfer, then records what must come back.
  task automatic offer_request(input request_t r, input logic typed, input result_t typed_res);
    result_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, r.old_prio, r.prio, r.value, r.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = next_queue_result(r);
    awaited_results.insert(awaited_results.size(), typed ? typed_res : predicted);
  endtask

  task automatic add_row(input mpq_pkg::cmd_t c, input logic [31:0] v, input logic [31:0] p,
                         input logic [31:0] op, input logic typed, input logic [31:0] ev,
                         input logic [31:0] ep, input mpq_pkg::status_t es, input int ec);
    directed_row_t row;
    row.req.cmd      = c;
    row.req.value    = v;
    row.req.prio     = p;
    row.req.old_prio = op;
    row.typed        = typed;
    row.res.value    = ev;
    row.res.prio     = ep;
    row.res.status   = es;
    row.res.count    = mpq_pkg::ENTRY_COUNT_W'(ec);
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic run_random(input int quota);
    int   sent;
    int   len;
    int   extra;
    mix_t mix;
    sent = 0;
    while (sent < quota) begin
      mix   = mix_t'($urandom_range(0, 2));
      len   = $urandom_range(10, 40);
      extra = $urandom_range(1, 3);
      for (int k = 0; k < 150 && sent < quota; k++) begin
        if (mix == MIX_EVEN && k >= len) break;
        // fill and drain runs go past the boundary by a few items
        if ((mix == MIX_FILL && shadow_count == mpq_pkg::QUEUE_DEPTH) ||
            (mix == MIX_DRAIN && shadow_count == 0)) begin
          if (extra == 0) break;
          extra = extra - 1;
        end
        offer_request(make_request(mix), 1'b0, '0);
        sent++;
      end
    end
  endtask

  // Reset and stimulus
  initial begin
    rst            <= 1'b1;
    s_tvalid       <= 1'b0;
    s_tdata        <= '0;
    mismatches     = 0;
    shadow_count   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_req   = 1'b0;

    // Directed: empty-queue errors, extremes, ties, modify hit and miss.
    add_row(mpq_pkg::CMD_FIND,    32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0,
            mpq_pkg::STAT_EMPTY, 0);
    add_row(mpq_pkg::CMD_EXTRACT, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0,
            mpq_pkg::STAT_EMPTY, 0);
    add_row(mpq_pkg::CMD_MODIFY,  32'h0, 32'h1, 32'h0, 1'b1, 32'h0, 32'h0,
            mpq_pkg::STAT_MISSING, 0);
    add_row(mpq_pkg::CMD_INSERT,  32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1,
            32'h0, 32'h0, mpq_pkg::STAT_OK, 1);
    add_row(mpq_pkg::CMD_FIND,    32'h0, 32'h0, 32'h0, 1'b1,
            32'h7FFF_FFFF, 32'h8000_0000, mpq_pkg::STAT_OK, 1);
    add_row(mpq_pkg::CMD_INSERT,  32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1,
            32'h0, 32'h0, mpq_pkg::STAT_OK, 2);
    add_row(mpq_pkg::CMD_INSERT,  32'h0, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 3);
    // tie on the top priority: earlier arrival is reported
    add_row(mpq_pkg::CMD_FIND,    32'h0, 32'h0, 32'h0, 1'b1,
            32'h8000_0000, 32'h7FFF_FFFF, mpq_pkg::STAT_OK, 3);
    add_row(mpq_pkg::CMD_MODIFY,  32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1,
            32'h0, 32'h0, mpq_pkg::STAT_OK, 3);
    add_row(mpq_pkg::CMD_MODIFY,  32'h0, 32'h5, 32'h7FFF_FFFF, 1'b1, 32'h0, 32'h0,
            mpq_pkg::STAT_MISSING, 3);
    // value matches but priority does not
    add_row(mpq_pkg::CMD_MODIFY,  32'h8000_0000, 32'h0, 32'h8000_0000, 1'b1,
            32'h0, 32'h0, mpq_pkg::STAT_MISSING, 3);
    add_row(mpq_pkg::CMD_EXTRACT, 32'h0, 32'h0, 32'h0, 1'b1,
            32'h8000_0000, 32'h7FFF_FFFF, mpq_pkg::STAT_OK, 2);
    add_row(mpq_pkg::CMD_EXTRACT, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_INSERT,  32'hFFFF_FFFF, 32'h8000_0000, 32'h0, 1'b0,
            32'h0, 32'h0, mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_EXTRACT, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_EXTRACT, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_EXTRACT, 32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 32'h0,
            mpq_pkg::STAT_EMPTY, 0);
    add_row(mpq_pkg::CMD_INSERT,  32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 1'b0,
            32'h0, 32'h0, mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_INSERT,  32'hAAAA_AAAA, 32'h5555_5555, 32'h0, 1'b0,
            32'h0, 32'h0, mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_MODIFY,  32'hAAAA_AAAA, 32'h8000_0000, 32'h5555_5555, 1'b0,
            32'h0, 32'h0, mpq_pkg::STAT_OK, 0);
    // duplicate entries: modify must touch only the first one
    add_row(mpq_pkg::CMD_INSERT,  32'h5, 32'h5, 32'h0, 1'b0, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_INSERT,  32'h5, 32'h5, 32'h0, 1'b0, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_MODIFY,  32'h5, 32'h9, 32'h5, 1'b0, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_FIND,    32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 0);
    add_row(mpq_pkg::CMD_EXTRACT, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 32'h0,
            mpq_pkg::STAT_OK, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      offer_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].res);
    end

    // No idling; the receiver holds off early on so the core backs up.
    hold_off_req = 1'b1;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct = 62;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct  = 0;
    recv_stall_pct = 62;
    run_random(RANDOM_ITEMS / 4);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    run_random(RANDOM_ITEMS / 4);

    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_max_priority_queue_linear_scan_core OK");
    end else begin
      $display("tb_max_priority_queue_linear_scan_core NOT OK");
    end
    $finish;
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    m_tready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        @(posedge clk);
      end
    end
  end

  // Result check: each transfer against the oldest expectation.
  always @(posedge clk) begin
    result_t awaited;
    result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.value  = m_tdata[31:0];
      got.prio   = m_tdata[63:32];
      got.status = mpq_pkg::status_t'(m_tdata[65:64]);
      got.count  = m_tdata[72:66];
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", m_tdata));
      end else begin
        awaited = awaited_results.pop_front();
        if (got.value !== awaited.value)
          report_mismatch($sformatf("out_value %h, want %h", got.value, awaited.value));
        if (got.prio !== awaited.prio)
          report_mismatch($sformatf("out_priority %h, want %h", got.prio, awaited.prio));
        if (got.status !== awaited.status)
          report_mismatch($sformatf("status %0d, want %0d", got.status, awaited.status));
        if (got.count !== awaited.count)
          report_mismatch($sformatf("entry_count %0d, want %0d", got.count, awaited.count));
      end
    end
  end

  // Hang detection: too long without a transfer on either side.
  initial begin
    quiet_cycles = 0;
    wait (!rst);
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles, %0d results pending",
                 $realtime, quiet_cycles, awaited_results.size());
        $display("tb_max_priority_queue_linear_scan_core NOT OK");
        $finish;
      end
    end
  end

endmodule
